FILE: hw/rtl/bmes_pkg.sv
// ----------------------------------------------------------------------------
// bmes_pkg
// Shared constants, types and tables for the bicycle model Euler step unit.
// ----------------------------------------------------------------------------
package bmes_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int ATAN_COUNT      = 24;
   localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_COUNT) ?
                                    TRIG_ITERATIONS : ATAN_COUNT;
   localparam int CNT_W           = $clog2(ATAN_COUNT + 1);
   localparam int CW              = 34;

   localparam logic [CW-1:0] CORDIC_START = CW'(652032874);
   localparam logic signed [23:0] RAD_TO_BAM_Q8 = 24'sd2670177;

   localparam logic [2:0] CSR_INV_WB   = 3'd0;
   localparam logic [2:0] CSR_TSTEP    = 3'd1;
   localparam logic [2:0] CSR_START_X  = 3'd2;
   localparam logic [2:0] CSR_START_Y  = 3'd3;
   localparam logic [2:0] CSR_START_ST = 3'd4;
   localparam logic [2:0] CSR_START_HD = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TRIG_S, ST_TRIG_H, ST_MUL_VT, ST_MUL_P, ST_MUL_DX, ST_MUL_DY,
      ST_MUL_M, ST_MUL_R, ST_MUL_DH, ST_MUL_DS, ST_UPDATE, ST_OUT
   } state_type;

   function automatic logic [CW-1:0] atan_lookup(input logic [CNT_W-1:0] idx);
      logic [CW-1:0] v;
      unique case (idx)
         5'd0:  v = CW'(536870912);
         5'd1:  v = CW'(316933406);
         5'd2:  v = CW'(167458907);
         5'd3:  v = CW'(85004756);
         5'd4:  v = CW'(42667331);
         5'd5:  v = CW'(21354465);
         5'd6:  v = CW'(10679838);
         5'd7:  v = CW'(5340245);
         5'd8:  v = CW'(2670163);
         5'd9:  v = CW'(1335087);
         5'd10: v = CW'(667544);
         5'd11: v = CW'(333772);
         5'd12: v = CW'(166886);
         5'd13: v = CW'(83443);
         5'd14: v = CW'(41722);
         5'd15: v = CW'(20861);
         5'd16: v = CW'(10430);
         5'd17: v = CW'(5215);
         5'd18: v = CW'(2608);
         5'd19: v = CW'(1304);
         5'd20: v = CW'(652);
         5'd21: v = CW'(326);
         5'd22: v = CW'(163);
         5'd23: v = CW'(81);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/bicycle_model_euler_step_unit.sv
// ----------------------------------------------------------------------------
// bicycle_model_euler_step_unit
// Keeps a vehicle pose and advances it by one kinematic bicycle Euler step.
//
// req_ carries one item: func in tuser (1 reloads the start pose), speed and
// steer_rate in tdata. rsp_ returns one item with the new pose and a
// saturation flag. csr_ writes inverse wheelbase, time step and start pose.
// One item is processed at a time. An integrate item runs two CORDIC passes
// and eight serial multiplies on one shared bit-serial multiplier, plus one
// update state that writes the new pose. A reload item loads the start pose
// and goes straight to the output register.
// The result sits in an output register; req_tready stays low until it is
// taken, so a stalled receiver holds the block. Reset clears the pose to
// zero and loads the register defaults.
// ----------------------------------------------------------------------------
module bicycle_model_euler_step_unit import bmes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // speed[15:0], steer_rate[31:16]
   input  logic         req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // pos_x, pos_y, steer_angle, heading
   output logic         rsp_tuser,   // saturated
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   state_type state_ff, state_in;
   logic [15:0] inv_wb_ff, tstep_ff, st_st_ff, st_hd_ff;
   logic [31:0] st_x_ff, st_y_ff;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [15:0] steer_ff, steer_in, head_ff, head_in;
   logic sat_ff, sat_in;
   logic signed [15:0] spd_ff, spd_in, rate_ff, rate_in;
   logic signed [16:0] ss_ff, ss_in, cs_ff, cs_in, sh_ff, sh_in, ch_ff, ch_in;
   logic signed [39:0] vt_ff, vt_in, p_ff, p_in, m_ff, m_in, r_ff, r_in;
   logic signed [39:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [15:0] dh_ff, dh_in;
   logic started_ff, started_in;

   logic               trig_start, trig_done, mul_start, mul_done;
   logic signed [15:0] trig_ang;
   logic signed [16:0] t_sin, t_cos;
   logic signed [39:0] mcand;
   logic signed [23:0] mplier;
   logic signed [63:0] prod, prod_r;
   logic [5:0]         rsh;
   logic signed [32:0] nx, ny;
   logic               req_ok;

   bmes_cordic u_cordic (
      .clock(clock), .reset(reset), .start(trig_start), .angle(trig_ang),
      .done(trig_done), .sin_out(t_sin), .cos_out(t_cos)
   );

   bmes_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .mcand(mcand),
      .mplier(mplier), .done(mul_done), .product(prod)
   );

   assign req_ok     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {head_ff, steer_ff, y_ff, x_ff};
   assign rsp_tuser  = sat_ff;

   always_comb begin
      rsh = 6'd15;
      unique case (state_ff)
         ST_MUL_DX, ST_MUL_DY: rsh = 6'd23;
         ST_MUL_R:             rsh = 6'd20;
         ST_MUL_DH:            rsh = 6'd24;
         ST_MUL_DS:            rsh = 6'd16;
         ST_MUL_VT:            rsh = 6'd0;
         default:              rsh = 6'd15;
      endcase
      prod_r = (rsh == 6'd0) ? prod :
               ((prod + (64'sd1 <<< (rsh - 6'd1))) >>> rsh);
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; steer_in = steer_ff; head_in = head_ff;
      sat_in = sat_ff; spd_in = spd_ff; rate_in = rate_ff;
      ss_in = ss_ff; cs_in = cs_ff; sh_in = sh_ff; ch_in = ch_ff;
      vt_in = vt_ff; p_in = p_ff; m_in = m_ff; r_in = r_ff;
      dx_in = dx_ff; dy_in = dy_ff; dh_in = dh_ff;
      started_in = 1'b1;
      trig_start = 1'b0; trig_ang = steer_ff;
      mul_start = 1'b0; mcand = '0; mplier = '0;
      nx = 33'(x_ff) + 33'(dx_ff);
      ny = 33'(y_ff) + 33'(dy_ff);
      unique case (state_ff)
         ST_IDLE: begin
            started_in = 1'b0;
            if (req_ok) begin
               spd_in  = $signed(req_tdata[15:0]);
               rate_in = $signed(req_tdata[31:16]);
               if (req_tuser) begin
                  x_in = st_x_ff; y_in = st_y_ff;
                  steer_in = st_st_ff; head_in = st_hd_ff;
                  sat_in = 1'b0; state_in = ST_OUT;
               end else begin
                  state_in = ST_TRIG_S;
               end
            end
         end
         ST_TRIG_S: begin
            trig_start = !started_ff; trig_ang = steer_ff;
            if (trig_done) begin
               ss_in = t_sin; cs_in = t_cos; state_in = ST_TRIG_H; started_in = 1'b0;
            end
         end
         ST_TRIG_H: begin
            trig_start = !started_ff; trig_ang = head_ff;
            if (trig_done) begin
               sh_in = t_sin; ch_in = t_cos; state_in = ST_MUL_VT; started_in = 1'b0;
            end
         end
         ST_MUL_VT: begin
            mul_start = !started_ff; mcand = 40'(spd_ff);
            mplier = $signed({8'd0, tstep_ff});
            if (mul_done) begin
               vt_in = prod_r[39:0]; state_in = ST_MUL_P; started_in = 1'b0;
            end
         end
         ST_MUL_P: begin
            mul_start = !started_ff; mcand = vt_ff; mplier = 24'(cs_ff);
            if (mul_done) begin
               p_in = prod_r[39:0]; state_in = ST_MUL_DX; started_in = 1'b0;
            end
         end
         ST_MUL_DX: begin
            mul_start = !started_ff; mcand = p_ff; mplier = 24'(ch_ff);
            if (mul_done) begin
               dx_in = prod_r[39:0]; state_in = ST_MUL_DY; started_in = 1'b0;
            end
         end
         ST_MUL_DY: begin
            mul_start = !started_ff; mcand = p_ff; mplier = 24'(sh_ff);
            if (mul_done) begin
               dy_in = prod_r[39:0]; state_in = ST_MUL_M; started_in = 1'b0;
            end
         end
         ST_MUL_M: begin
            mul_start = !started_ff; mcand = vt_ff; mplier = 24'(ss_ff);
            if (mul_done) begin
               m_in = prod_r[39:0]; state_in = ST_MUL_R; started_in = 1'b0;
            end
         end
         ST_MUL_R: begin
            mul_start = !started_ff; mcand = m_ff;
            mplier = $signed({8'd0, inv_wb_ff});
            if (mul_done) begin
               r_in = prod_r[39:0]; state_in = ST_MUL_DH; started_in = 1'b0;
            end
         end
         ST_MUL_DH: begin
            mul_start = !started_ff; mcand = r_ff; mplier = RAD_TO_BAM_Q8;
            if (mul_done) begin
               dh_in = prod_r[15:0]; state_in = ST_MUL_DS; started_in = 1'b0;
            end
         end
         ST_MUL_DS: begin
            mul_start = !started_ff; mcand = 40'(rate_ff);
            mplier = $signed({8'd0, tstep_ff});
            if (mul_done) begin
               steer_in = steer_ff + prod_r[15:0];
               state_in = ST_UPDATE; started_in = 1'b0;
            end
         end
         ST_UPDATE: begin
            sat_in = 1'b0;
            if (nx > 33'sh0_7FFF_FFFF) begin
               x_in = 32'sh7FFF_FFFF; sat_in = 1'b1;
            end else if (nx < -33'sh0_8000_0000) begin
               x_in = 32'sh8000_0000; sat_in = 1'b1;
            end else x_in = nx[31:0];
            if (ny > 33'sh0_7FFF_FFFF) begin
               y_in = 32'sh7FFF_FFFF; sat_in = 1'b1;
            end else if (ny < -33'sh0_8000_0000) begin
               y_in = 32'sh8000_0000; sat_in = 1'b1;
            end else y_in = ny[31:0];
            head_in = head_ff + dh_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      spd_ff <= spd_in; rate_ff <= rate_in;
      ss_ff <= ss_in; cs_ff <= cs_in; sh_ff <= sh_in; ch_ff <= ch_in;
      vt_ff <= vt_in; p_ff <= p_in; m_ff <= m_in; r_ff <= r_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dh_ff <= dh_in;
      if (reset) begin
         state_ff <= ST_IDLE; started_ff <= 1'b0;
         x_ff <= '0; y_ff <= '0; steer_ff <= '0; head_ff <= '0; sat_ff <= 1'b0;
         inv_wb_ff <= 16'd1638; tstep_ff <= 16'd655;
         st_x_ff <= '0; st_y_ff <= '0; st_st_ff <= '0; st_hd_ff <= '0;
      end else begin
         state_ff <= state_in; started_ff <= started_in;
         x_ff <= x_in; y_ff <= y_in; steer_ff <= steer_in; head_ff <= head_in;
         sat_ff <= sat_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_INV_WB:   inv_wb_ff <= csr_wdata[15:0];
               CSR_TSTEP:    tstep_ff  <= csr_wdata[15:0];
               CSR_START_X:  st_x_ff   <= csr_wdata;
               CSR_START_Y:  st_y_ff   <= csr_wdata;
               CSR_START_ST: st_st_ff  <= csr_wdata[15:0];
               CSR_START_HD: st_hd_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(trig_start && mul_start)) else $error("cordic and multiplier both started");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");

endmodule

FILE: hw/rtl/bmes_cordic.sv
// ----------------------------------------------------------------------------
// bmes_cordic
// Iterative rotation-mode CORDIC, one step per cycle, sin and cos in Q1.15.
// ----------------------------------------------------------------------------
module bmes_cordic import bmes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [15:0]  angle,
   output logic                done,
   output logic signed [16:0]  sin_out,
   output logic signed [16:0]  cos_out
);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [16:0]   a_fold;
   logic signed [CW-1:0] xs, ys, xr, yr;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      a_fold = 17'(angle);
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      if (start) begin
         neg_in = 1'b0;
         if (angle > 16'sd16384) begin
            a_fold = 17'(angle) - 17'sd32768; neg_in = 1'b1;
         end else if (angle < -16'sd16384) begin
            a_fold = 17'(angle) + 17'sd32768; neg_in = 1'b1;
         end
         x_in = CORDIC_START; y_in = '0;
         z_in = CW'($signed({a_fold, 16'd0}));
         cnt_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (32'(cnt_ff) == CORDIC_STEPS) begin
            busy_in = 1'b0; done_in = 1'b1;
         end else begin
            if (!z_ff[CW-1]) begin
               x_in = x_ff - ys; y_in = y_ff + xs;
               z_in = z_ff - $signed(atan_lookup(cnt_ff));
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs;
               z_in = z_ff + $signed(atan_lookup(cnt_ff));
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign xr = (x_ff + CW'(16384)) >>> 15;
   assign yr = (y_ff + CW'(16384)) >>> 15;
   assign cos_out = neg_ff ? -xr[16:0] : xr[16:0];
   assign sin_out = neg_ff ? -yr[16:0] : yr[16:0];
   assign done    = done_ff;

endmodule

FILE: hw/rtl/bmes_serial_mul.sv
// ----------------------------------------------------------------------------
// bmes_serial_mul
// Signed shift-add multiplier, one multiplier bit per cycle, 40 by 24 bits.
// ----------------------------------------------------------------------------
module bmes_serial_mul import bmes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [39:0]  mcand,
   input  logic signed [23:0]  mplier,
   output logic                done,
   output logic signed [63:0]  product
);

   logic signed [63:0] acc_ff, acc_in, mc_ff, mc_in;
   logic [23:0]        mp_ff, mp_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = '0; mc_in = 64'(mcand); mp_in = mplier; cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_in = (cnt_ff == 5'd23) ? acc_ff - mc_ff : acc_ff + mc_ff;
         end
         mc_in = mc_ff <<< 1;
         mp_in = mp_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; mc_ff <= mc_in; mp_ff <= mp_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
